@@ src/sstf_disk_request_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// SSTF scheduler assertion macros
// Concurrent assertion shorthands; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define SSTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstf assertion failed");

// next-cycle implication, disabled in reset
`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstf assertion failed");

`else

`define SSTF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/sstf_pkg.sv @@
// ----------------------------------------------------------------------------
// sstf_pkg
// Types and constants shared by the SSTF disk request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

    localparam int ARR_W     = 16;
    localparam int TRACK_W   = 10;
    localparam int SECTOR_W  = 8;
    localparam int SPT_W     = 9;
    localparam int OVH_W     = 16;
    localparam int COST_W    = 8;
    localparam int TIME_W    = 24;
    localparam int REQNUM_W  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0]   TIME_MAX = {TIME_W{1'b1}};

    localparam logic [TRACK_W-1:0]  RST_START_TRACK  = 10'd100;
    localparam logic [SECTOR_W-1:0] RST_START_SECTOR = 8'd0;
    localparam logic [SPT_W-1:0]    RST_SPT          = 9'd8;
    localparam logic [OVH_W-1:0]    RST_OVERHEAD     = 16'd110;
    localparam logic [COST_W-1:0]   RST_SEEK_COST    = 8'd1;
    localparam logic [COST_W-1:0]   RST_SECTOR_COST  = 8'd10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_TRACK  = 3'd0,
        CFG_START_SECTOR = 3'd1,
        CFG_SPT          = 3'd2,
        CFG_OVERHEAD     = 3'd3,
        CFG_SEEK_COST    = 3'd4,
        CFG_SECTOR_COST  = 3'd5
    } sstf_cfg_idx_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PREP,
        S_PREP_W,
        S_SCAN,
        S_SEL,
        S_MOD_W,
        S_MULT,
        S_SUM,
        S_EMIT
    } sstf_state_t;

    typedef struct packed {
        logic [ARR_W-1:0]    arrival_ms;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic                last_of_set;
    } sstf_in_t;

    typedef struct packed {
        logic [REQNUM_W-1:0] request_number;
        logic [TIME_W-1:0]   finish_tenths;
        logic                last_of_run;
    } sstf_out_t;

    // one stored request as it travels around the cell ring
    typedef struct packed {
        logic                valid;
        logic                served;
        logic [ARR_W-1:0]    arrival;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
    } req_cell_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/sstf_cell.sv @@
// ----------------------------------------------------------------------------
// sstf_cell
// One slot of the request ring; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_cell #(
    parameter int IDX_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sstf_pkg::cell_ctrl_t ctrl,
    input  wire sstf_pkg::req_cell_t  entry_in,
    input  wire logic [IDX_W-1:0]     idx_in,
    output sstf_pkg::req_cell_t       entry_out,
    output logic [IDX_W-1:0]          idx_out
);
    import sstf_pkg::*;

    logic                valid_reg;
    logic                served_reg;
    logic [ARR_W-1:0]    arrival_reg;
    logic [TRACK_W-1:0]  track_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [IDX_W-1:0]    idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            served_reg  <= entry_in.served;
            arrival_reg <= entry_in.arrival;
            track_reg   <= entry_in.track;
            sector_reg  <= entry_in.sector;
            idx_reg     <= idx_in;
        end
    end

    assign entry_out = '{valid:   valid_reg,
                         served:  served_reg,
                         arrival: arrival_reg,
                         track:   track_reg,
                         sector:  sector_reg};
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire

@@ src/sstf_mod.sv @@
// ----------------------------------------------------------------------------
// sstf_mod
// Restoring remainder unit: sector modulo sectors-per-track, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sstf_pkg::SECTOR_W-1:0] dividend,
    input  wire logic [sstf_pkg::SPT_W-1:0]    divisor,
    output logic                               done,
    output logic [sstf_pkg::SECTOR_W-1:0]      remainder
);
    import sstf_pkg::*;

    localparam int STEP_W = $clog2(SECTOR_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SECTOR_W-1:0] dvd_reg;
    logic [SPT_W-1:0]    rem_reg;

    logic [SPT_W:0]      trial;
    logic [SPT_W:0]      diff;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[SECTOR_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SECTOR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SECTOR_W-2:0], 1'b0};
            rem_reg <= fits ? diff[SPT_W-1:0] : trial[SPT_W-1:0];
        end
    end

    assign done      = done_reg;
    // remainder never exceeds the dividend, so it fits the sector width
    assign remainder = rem_reg[SECTOR_W-1:0];

endmodule

`default_nettype wire

@@ src/sstf_disk_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-time-first scheduler over a batch of buffered disk requests.
// ----------------------------------------------------------------------------
// Requests load one per cycle into a ring of MAX_REQUESTS cells; the request
// flagged last_of_set closes the batch and scheduling starts (any request
// beyond MAX_REQUESTS is dropped). Each dispatch rotates the ring once around,
// comparing one entry per cycle at the ring tail, then runs the sector
// remainder (8-step serial unit), the two cost products, the cost sum and the
// result write. The start sector is reduced once per batch, before the first
// pass. Results leave through a single output register; loading of the next
// batch can begin while the final result still waits there.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sstf_disk_request_scheduler_defines.svh"

module sstf_disk_request_scheduler #(
    parameter int MAX_REQUESTS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sstf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [sstf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire sstf_pkg::sstf_in_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sstf_pkg::sstf_out_t                    out_data
);
    import sstf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_REQUESTS);
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int A10_W  = ARR_W + 4;
    localparam int ROT_W  = SPT_W;
    localparam int PSK_W  = COST_W + TRACK_W;
    localparam int PRT_W  = COST_W + ROT_W;
    localparam int SUM_W  = PSK_W + 1;

    // configuration
    logic [TRACK_W-1:0]  cfg_start_track_reg;
    logic [SECTOR_W-1:0] cfg_start_sector_reg;
    logic [SPT_W-1:0]    cfg_spt_reg;
    logic [OVH_W-1:0]    cfg_overhead_reg;
    logic [COST_W-1:0]   cfg_seek_cost_reg;
    logic [COST_W-1:0]   cfg_sector_cost_reg;
    logic [SPT_W-1:0]    spt_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_start_track_reg  <= RST_START_TRACK;
            cfg_start_sector_reg <= RST_START_SECTOR;
            cfg_spt_reg          <= RST_SPT;
            cfg_overhead_reg     <= RST_OVERHEAD;
            cfg_seek_cost_reg    <= RST_SEEK_COST;
            cfg_sector_cost_reg  <= RST_SECTOR_COST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_START_TRACK:  cfg_start_track_reg  <= cfg_wdata[TRACK_W-1:0];
                CFG_START_SECTOR: cfg_start_sector_reg <= cfg_wdata[SECTOR_W-1:0];
                CFG_SPT:          cfg_spt_reg          <= cfg_wdata[SPT_W-1:0];
                CFG_OVERHEAD:     cfg_overhead_reg     <= cfg_wdata[OVH_W-1:0];
                CFG_SEEK_COST:    cfg_seek_cost_reg    <= cfg_wdata[COST_W-1:0];
                CFG_SECTOR_COST:  cfg_sector_cost_reg  <= cfg_wdata[COST_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero sectors per track behaves as one
    assign spt_eff = (cfg_spt_reg == '0) ? SPT_W'(1) : cfg_spt_reg;

    // control state
    sstf_state_t         state_reg;
    sstf_state_t         state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [IDX_W-1:0]    scan_cnt_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TRACK_W-1:0]  head_track_reg;
    logic [SECTOR_W-1:0] head_sec_reg;
    logic                sel_valid_reg;
    logic [IDX_W-1:0]    sel_idx_reg;
    logic                out_valid_reg;
    sstf_out_t           out_data_reg;

    // best arrived candidate (nearest track)
    logic                fa_reg;
    logic [TRACK_W-1:0]  a_dist_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [TRACK_W-1:0]  a_track_reg;
    logic [SECTOR_W-1:0] a_sector_reg;
    // best candidate by earliest arrival
    logic                fe_reg;
    logic [ARR_W-1:0]    e_arr_reg;
    logic [IDX_W-1:0]    e_idx_reg;
    logic [TRACK_W-1:0]  e_track_reg;
    logic [SECTOR_W-1:0] e_sector_reg;

    // chosen request and cost pipeline
    logic [IDX_W-1:0]    ch_idx_reg;
    logic [TRACK_W-1:0]  ch_track_reg;
    logic [TIME_W-1:0]   ch_start_reg;
    logic [TRACK_W-1:0]  ch_dist_reg;
    logic [SECTOR_W-1:0] smod_reg;
    logic [ROT_W-1:0]    rot_reg;
    logic [PSK_W-1:0]    p_seek_reg;
    logic [PRT_W-1:0]    p_rot_reg;
    logic [SUM_W-1:0]    cost_reg;

    logic in_acc;
    logic room;
    logic scan_last;
    logic scan_init;
    logic out_free;
    logic last_disp;
    logic [CNT_W-1:0] k_plus;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign room      = (count_reg < CNT_W'(MAX_REQUESTS));
    assign scan_last = (state_reg == S_SCAN) && (scan_cnt_reg == IDX_W'(MAX_REQUESTS - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign k_plus    = k_reg + CNT_W'(1);
    assign last_disp = (k_plus == count_reg);

    // remainder unit
    logic                mod_start;
    logic                mod_done;
    logic [SECTOR_W-1:0] mod_dvd;
    logic [SECTOR_W-1:0] mod_rem;

    // ring of cells
    cell_ctrl_t          cell_ctrl;
    req_cell_t           ring_ent [MAX_REQUESTS];
    logic [IDX_W-1:0]    ring_idx [MAX_REQUESTS];
    req_cell_t           ring_in;
    logic [IDX_W-1:0]    ring_in_idx;
    req_cell_t           tail;
    logic [IDX_W-1:0]    tail_idx;

    assign tail     = ring_ent[MAX_REQUESTS-1];
    assign tail_idx = ring_idx[MAX_REQUESTS-1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQUESTS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                sstf_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (cell_ctrl),
                    .entry_in  (ring_in),
                    .idx_in    (ring_in_idx),
                    .entry_out (ring_ent[gi]),
                    .idx_out   (ring_idx[gi])
                );
            end
            else
            begin : g_body
                sstf_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (cell_ctrl),
                    .entry_in  (ring_ent[gi-1]),
                    .idx_in    (ring_idx[gi-1]),
                    .entry_out (ring_ent[gi]),
                    .idx_out   (ring_idx[gi])
                );
            end
        end
    endgenerate

    // tail evaluation; the previous pick is marked served as it passes
    logic                served_eff;
    logic                elig;
    logic [A10_W-1:0]    tail_a10;
    logic                arrived;
    logic [TRACK_W-1:0]  seek_dist;
    logic                better_a;
    logic                better_e;
    logic                upd_a;
    logic                upd_e;

    assign served_eff = tail.served || (sel_valid_reg && (tail_idx == sel_idx_reg));
    assign elig       = tail.valid && !served_eff;
    assign tail_a10   = ({4'b0, tail.arrival} << 3) + ({4'b0, tail.arrival} << 1);
    assign arrived    = ({{(TIME_W-A10_W){1'b0}}, tail_a10} <= now_reg);
    assign seek_dist  = (head_track_reg >= tail.track) ? (head_track_reg - tail.track)
                                                       : (tail.track - head_track_reg);
    assign better_a   = !fa_reg || (seek_dist < a_dist_reg)
                        || ((seek_dist == a_dist_reg) && (tail_idx < a_idx_reg));
    assign better_e   = !fe_reg || (tail.arrival < e_arr_reg)
                        || ((tail.arrival == e_arr_reg) && (tail_idx < e_idx_reg));
    assign upd_a      = (state_reg == S_SCAN) && elig && arrived && better_a;
    assign upd_e      = (state_reg == S_SCAN) && elig && better_e;

    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            ring_in     = '{valid:   1'b1,
                            served:  1'b0,
                            arrival: in_data.arrival_ms,
                            track:   in_data.track,
                            sector:  in_data.sector};
            ring_in_idx = count_reg[IDX_W-1:0];
        end
        else
        begin
            ring_in        = tail;
            ring_in.served = served_eff;
            ring_in_idx    = tail_idx;
        end
    end

    assign cell_ctrl.shift = (in_acc && room) || (state_reg == S_SCAN);
    assign cell_ctrl.clear = (state_reg == S_EMIT) && out_free && last_disp;

    // selection after the pass
    logic [A10_W-1:0]    e_a10;
    logic [TIME_W-1:0]   e_start;
    logic [TRACK_W-1:0]  sel_track;
    logic [TRACK_W-1:0]  sel_dist;

    assign e_a10     = ({4'b0, e_arr_reg} << 3) + ({4'b0, e_arr_reg} << 1);
    assign e_start   = ({{(TIME_W-A10_W){1'b0}}, e_a10} > now_reg)
                       ? {{(TIME_W-A10_W){1'b0}}, e_a10} : now_reg;
    assign sel_track = fa_reg ? a_track_reg : e_track_reg;
    assign sel_dist  = (head_track_reg >= sel_track) ? (head_track_reg - sel_track)
                                                     : (sel_track - head_track_reg);

    assign mod_start = (state_reg == S_PREP) || (state_reg == S_SEL);
    assign mod_dvd   = (state_reg == S_PREP) ? cfg_start_sector_reg
                                             : (fa_reg ? a_sector_reg : e_sector_reg);

    sstf_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (spt_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    logic [ROT_W-1:0]  rot_calc;
    logic [TIME_W:0]   fin_wide;
    logic [TIME_W-1:0] fin_sat;

    assign rot_calc = (mod_rem >= head_sec_reg)
                      ? ROT_W'(mod_rem - head_sec_reg)
                      : ROT_W'({1'b0, mod_rem} + spt_eff - {1'b0, head_sec_reg});
    assign fin_wide = {1'b0, ch_start_reg} + {{(TIME_W+1-SUM_W){1'b0}}, cost_reg};
    assign fin_sat  = fin_wide[TIME_W] ? TIME_MAX : fin_wide[TIME_W-1:0];

    assign scan_init = ((state_reg == S_PREP_W) && mod_done)
                       || ((state_reg == S_EMIT) && out_free && !last_disp);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:   if (in_acc && in_data.last_of_set) state_next = S_PREP;
            S_PREP:   state_next = S_PREP_W;
            S_PREP_W: if (mod_done) state_next = S_SCAN;
            S_SCAN:   if (scan_last) state_next = S_SEL;
            S_SEL:    state_next = S_MOD_W;
            S_MOD_W:  if (mod_done) state_next = S_MULT;
            S_MULT:   state_next = S_SUM;
            S_SUM:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_disp ? S_LOAD : S_SCAN;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            k_reg          <= '0;
            scan_cnt_reg   <= '0;
            now_reg        <= '0;
            head_track_reg <= RST_START_TRACK;
            head_sec_reg   <= RST_START_SECTOR;
            sel_valid_reg  <= 1'b0;
            sel_idx_reg    <= '0;
            fa_reg         <= 1'b0;
            fe_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (in_acc && in_data.last_of_set)
            begin
                head_track_reg <= cfg_start_track_reg;
                now_reg        <= '0;
                k_reg          <= '0;
                sel_valid_reg  <= 1'b0;
            end

            if (state_reg == S_PREP_W && mod_done)
            begin
                head_sec_reg <= mod_rem;
            end

            if (scan_init)
            begin
                scan_cnt_reg <= '0;
                fa_reg       <= 1'b0;
                fe_reg       <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                if (upd_a)
                begin
                    fa_reg <= 1'b1;
                end
                if (upd_e)
                begin
                    fe_reg <= 1'b1;
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg  <= 1'b1;
                now_reg        <= fin_sat;
                head_track_reg <= ch_track_reg;
                head_sec_reg   <= smod_reg;
                sel_valid_reg  <= 1'b1;
                sel_idx_reg    <= ch_idx_reg;
                k_reg          <= k_plus;
                if (last_disp)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_a)
        begin
            a_dist_reg   <= seek_dist;
            a_idx_reg    <= tail_idx;
            a_track_reg  <= tail.track;
            a_sector_reg <= tail.sector;
        end
        if (upd_e)
        begin
            e_arr_reg    <= tail.arrival;
            e_idx_reg    <= tail_idx;
            e_track_reg  <= tail.track;
            e_sector_reg <= tail.sector;
        end

        if (state_reg == S_SEL)
        begin
            ch_idx_reg   <= fa_reg ? a_idx_reg : e_idx_reg;
            ch_track_reg <= sel_track;
            ch_dist_reg  <= sel_dist;
            ch_start_reg <= fa_reg ? now_reg : e_start;
        end

        if (state_reg == S_MOD_W && mod_done)
        begin
            smod_reg <= mod_rem;
            rot_reg  <= rot_calc;
        end

        if (state_reg == S_MULT)
        begin
            p_seek_reg <= cfg_seek_cost_reg * ch_dist_reg;
            p_rot_reg  <= cfg_sector_cost_reg * rot_reg;
        end

        if (state_reg == S_SUM)
        begin
            cost_reg <= {{(SUM_W-OVH_W){1'b0}}, cfg_overhead_reg}
                        + {1'b0, p_seek_reg}
                        + {{(SUM_W-PRT_W){1'b0}}, p_rot_reg};
        end

        if (state_reg == S_EMIT && out_free)
        begin
            out_data_reg.request_number <= REQNUM_W'(ch_idx_reg);
            out_data_reg.finish_tenths  <= fin_sat;
            out_data_reg.last_of_run    <= last_disp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `SSTF_ASSERT_NOW(a_mod_done_expected, clk, rst_n, mod_done, (state_reg == S_PREP_W) || (state_reg == S_MOD_W))
    `SSTF_ASSERT_NOW(a_scan_has_work, clk, rst_n, (state_reg == S_SCAN), (k_reg < count_reg))
    `SSTF_ASSERT_NOW(a_pick_in_batch, clk, rst_n, (state_reg == S_SCAN) && sel_valid_reg, (CNT_W'(sel_idx_reg) < count_reg))
    `SSTF_ASSERT_NEXT(a_last_returns_load, clk, rst_n, (state_reg == S_EMIT) && out_free && last_disp, (state_reg == S_LOAD) && (count_reg == '0))

endmodule

`default_nettype wire
